[hw/rtl/kf1d_pkg.sv]
package kf1d_pkg;

    localparam int MeanW    = 32;
    localparam int VarW     = 48;
    localparam int SumW     = VarW + 1;
    localparam int MagW     = MeanW + 1;
    localparam int TmpW     = SumW + 2;
    localparam int FracPad  = SumW - MagW;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 48;
    localparam int CntW     = 6;

    localparam int MeanSteps = MagW;
    localparam int VarSteps  = SumW;

    typedef logic signed [MeanW-1:0] mean_t;
    typedef logic [VarW-1:0]         var_t;

    localparam var_t  MeasVarRst   = 48'd1048576;
    localparam var_t  MotionVarRst = 48'd262144;
    localparam mean_t InitMeanRst  = 32'sd0;
    localparam var_t  InitVarRst   = 48'd65536000000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MEAS_VAR   = 8'd0,
        CFG_MOTION_VAR = 8'd1,
        CFG_INIT_MEAN  = 8'd2,
        CFG_INIT_VAR   = 8'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MEAN_START,
        S_MEAN_RUN,
        S_MEAN_SAVE,
        S_VAR_RUN,
        S_VAR_SAVE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic zero;
        logic start_mean;
        logic start_var;
        logic step;
        logic save_mean;
        logic save_var;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic s_zero;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/kf1d_if.sv]
interface kf1d_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [kf1d_pkg::MeanW-1:0] measurement;
    logic signed [kf1d_pkg::MeanW-1:0] motion;
    logic                          restart;

    modport source (output valid, output measurement, output motion, output restart,
                    input ready);
    modport sink   (input valid, input measurement, input motion, input restart,
                    output ready);
endinterface

interface kf1d_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [kf1d_pkg::MeanW-1:0] updated_mean;
    logic [kf1d_pkg::VarW-1:0]         updated_variance;
    logic signed [kf1d_pkg::MeanW-1:0] predicted_mean;
    logic [kf1d_pkg::VarW-1:0]         predicted_variance;

    modport source (output valid, output updated_mean, output updated_variance,
                    output predicted_mean, output predicted_variance, input ready);
    modport sink   (input valid, input updated_mean, input updated_variance,
                    input predicted_mean, input predicted_variance, output ready);
endinterface

[hw/rtl/kf1d_ctrl.sv]
module kf1d_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kf1d_pkg::status_t  status,
    output kf1d_pkg::cmd_t     cmd
);

    kf1d_pkg::state_t              state_reg;
    kf1d_pkg::state_t              state_next;
    logic [kf1d_pkg::CntW-1:0]     cnt_reg;
    logic [kf1d_pkg::CntW-1:0]     cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kf1d_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            kf1d_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kf1d_pkg::S_PREP;
                end
            end
            kf1d_pkg::S_PREP:
            begin
                state_next = kf1d_pkg::S_MEAN_START;
            end
            kf1d_pkg::S_MEAN_START:
            begin
                if (status.s_zero)
                begin
                    state_next = kf1d_pkg::S_FINISH;
                end
                else
                begin
                    state_next = kf1d_pkg::S_MEAN_RUN;
                    cnt_next   = kf1d_pkg::CntW'(kf1d_pkg::MeanSteps - 1);
                end
            end
            kf1d_pkg::S_MEAN_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = kf1d_pkg::S_MEAN_SAVE;
                end
                else
                begin
                    cnt_next = cnt_reg - kf1d_pkg::CntW'(1);
                end
            end
            kf1d_pkg::S_MEAN_SAVE:
            begin
                state_next = kf1d_pkg::S_VAR_RUN;
                cnt_next   = kf1d_pkg::CntW'(kf1d_pkg::VarSteps - 1);
            end
            kf1d_pkg::S_VAR_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = kf1d_pkg::S_VAR_SAVE;
                end
                else
                begin
                    cnt_next = cnt_reg - kf1d_pkg::CntW'(1);
                end
            end
            kf1d_pkg::S_VAR_SAVE:
            begin
                state_next = kf1d_pkg::S_FINISH;
            end
            kf1d_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = kf1d_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kf1d_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            kf1d_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            kf1d_pkg::S_PREP:
            begin
                cmd.prep = 1'b1;
            end
            kf1d_pkg::S_MEAN_START:
            begin
                cmd.zero       = status.s_zero;
                cmd.start_mean = !status.s_zero;
            end
            kf1d_pkg::S_MEAN_RUN:
            begin
                cmd.step = 1'b1;
            end
            kf1d_pkg::S_MEAN_SAVE:
            begin
                cmd.save_mean = 1'b1;
                cmd.start_var = 1'b1;
            end
            kf1d_pkg::S_VAR_RUN:
            begin
                cmd.step = 1'b1;
            end
            kf1d_pkg::S_VAR_SAVE:
            begin
                cmd.save_var = 1'b1;
            end
            kf1d_pkg::S_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result is written only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> status.out_free)
        else $error("finish issued while output register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.load |=> state_reg == kf1d_pkg::S_PREP)
        else $error("accepted item did not start processing");

endmodule

[hw/rtl/kf1d_dp.sv]
module kf1d_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [kf1d_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [kf1d_pkg::CfgDataW-1:0]   cfg_data,
    kf1d_in_if.sink                         sample,
    kf1d_out_if.source                      result,
    input  kf1d_pkg::cmd_t                  cmd,
    output kf1d_pkg::status_t               status
);

    kf1d_pkg::var_t  rm_reg;
    kf1d_pkg::var_t  mvar_reg;
    kf1d_pkg::mean_t imean_reg;
    kf1d_pkg::var_t  ivar_reg;

    kf1d_pkg::mean_t est_m_reg;
    kf1d_pkg::var_t  est_v_reg;

    kf1d_pkg::mean_t z_reg;
    kf1d_pkg::mean_t mot_reg;

    logic [kf1d_pkg::SumW-1:0]  s_reg;
    logic [kf1d_pkg::MagW-1:0]  mag_reg;
    logic                       neg_reg;

    logic [kf1d_pkg::SumW-1:0]  a_reg;
    kf1d_pkg::var_t             b_reg;
    logic [kf1d_pkg::SumW-1:0]  r_reg;
    kf1d_pkg::var_t             q_reg;

    kf1d_pkg::mean_t um_reg;
    kf1d_pkg::var_t  uv_reg;

    logic            out_valid_reg;
    kf1d_pkg::mean_t out_um_reg;
    kf1d_pkg::var_t  out_uv_reg;
    kf1d_pkg::mean_t out_pm_reg;
    kf1d_pkg::var_t  out_pv_reg;

    logic signed [kf1d_pkg::MagW-1:0] d_c;
    logic [kf1d_pkg::MagW-1:0]        mag_c;
    logic [kf1d_pkg::TmpW-1:0]        t_c;
    logic [kf1d_pkg::TmpW-1:0]        s1_c;
    logic [kf1d_pkg::TmpW-1:0]        s2_c;
    logic [kf1d_pkg::SumW-1:0]        r_c;
    logic [1:0]                       digit_c;
    kf1d_pkg::var_t                   q_c;
    logic signed [kf1d_pkg::MagW:0]   um_c;
    logic signed [kf1d_pkg::MagW-1:0] pm_sum_c;
    kf1d_pkg::mean_t                  pm_c;
    logic [kf1d_pkg::SumW-1:0]        pv_sum_c;
    kf1d_pkg::var_t                   pv_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_reg    <= kf1d_pkg::MeasVarRst;
            mvar_reg  <= kf1d_pkg::MotionVarRst;
            imean_reg <= kf1d_pkg::InitMeanRst;
            ivar_reg  <= kf1d_pkg::InitVarRst;
        end
        else if (cfg_write_en)
        begin
            case (kf1d_pkg::cfg_idx_t'(cfg_index))
                kf1d_pkg::CFG_MEAS_VAR:   rm_reg    <= cfg_data[kf1d_pkg::VarW-1:0];
                kf1d_pkg::CFG_MOTION_VAR: mvar_reg  <= cfg_data[kf1d_pkg::VarW-1:0];
                kf1d_pkg::CFG_INIT_MEAN:  imean_reg <= cfg_data[kf1d_pkg::MeanW-1:0];
                kf1d_pkg::CFG_INIT_VAR:   ivar_reg  <= cfg_data[kf1d_pkg::VarW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_m_reg <= kf1d_pkg::InitMeanRst;
            est_v_reg <= kf1d_pkg::InitVarRst;
        end
        else if (cmd.load && sample.restart)
        begin
            est_m_reg <= imean_reg;
            est_v_reg <= ivar_reg;
        end
        else if (cmd.finish)
        begin
            est_m_reg <= pm_c;
            est_v_reg <= pv_c;
        end
    end

    assign d_c   = {z_reg[kf1d_pkg::MeanW-1], z_reg}
                 - {est_m_reg[kf1d_pkg::MeanW-1], est_m_reg};
    assign mag_c = d_c[kf1d_pkg::MagW-1] ? kf1d_pkg::MagW'(-d_c) : kf1d_pkg::MagW'(d_c);

    // One multiply-divide step: shift in the next multiplier bit, then remove
    // zero, one or two multiples of the divisor (the partial value stays below 3*s).
    assign t_c  = {1'b0, r_reg, 1'b0}
                + (a_reg[kf1d_pkg::SumW-1] ? kf1d_pkg::TmpW'(b_reg) : '0);
    assign s1_c = kf1d_pkg::TmpW'(s_reg);
    assign s2_c = kf1d_pkg::TmpW'({s_reg, 1'b0});

    always_comb
    begin
        if (t_c >= s2_c)
        begin
            digit_c = 2'd2;
            r_c     = kf1d_pkg::SumW'(t_c - s2_c);
        end
        else if (t_c >= s1_c)
        begin
            digit_c = 2'd1;
            r_c     = kf1d_pkg::SumW'(t_c - s1_c);
        end
        else
        begin
            digit_c = 2'd0;
            r_c     = kf1d_pkg::SumW'(t_c);
        end
    end

    assign q_c = {q_reg[kf1d_pkg::VarW-2:0], 1'b0} + kf1d_pkg::VarW'(digit_c);

    assign um_c = neg_reg
                ? ({{2{est_m_reg[kf1d_pkg::MeanW-1]}}, est_m_reg}
                   - {1'b0, q_reg[kf1d_pkg::MagW-1:0]})
                : ({{2{est_m_reg[kf1d_pkg::MeanW-1]}}, est_m_reg}
                   + {1'b0, q_reg[kf1d_pkg::MagW-1:0]});

    assign pm_sum_c = {um_reg[kf1d_pkg::MeanW-1], um_reg}
                    + {mot_reg[kf1d_pkg::MeanW-1], mot_reg};

    always_comb
    begin
        if (pm_sum_c[kf1d_pkg::MagW-1] != pm_sum_c[kf1d_pkg::MeanW-1])
        begin
            pm_c = {pm_sum_c[kf1d_pkg::MagW-1], {(kf1d_pkg::MeanW-1){!pm_sum_c[kf1d_pkg::MagW-1]}}};
        end
        else
        begin
            pm_c = pm_sum_c[kf1d_pkg::MeanW-1:0];
        end
    end

    assign pv_sum_c = {1'b0, uv_reg} + {1'b0, mvar_reg};
    assign pv_c     = pv_sum_c[kf1d_pkg::VarW] ? '1 : pv_sum_c[kf1d_pkg::VarW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg   <= sample.measurement;
            mot_reg <= sample.motion;
        end
        if (cmd.prep)
        begin
            s_reg   <= {1'b0, est_v_reg} + {1'b0, rm_reg};
            mag_reg <= mag_c;
            neg_reg <= d_c[kf1d_pkg::MagW-1];
        end
        if (cmd.start_mean)
        begin
            a_reg <= {mag_reg, {kf1d_pkg::FracPad{1'b0}}};
            b_reg <= est_v_reg;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (cmd.start_var)
        begin
            a_reg <= {1'b0, est_v_reg};
            b_reg <= rm_reg;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (cmd.step)
        begin
            a_reg <= {a_reg[kf1d_pkg::SumW-2:0], 1'b0};
            r_reg <= r_c;
            q_reg <= q_c;
        end
        if (cmd.save_mean)
        begin
            um_reg <= um_c[kf1d_pkg::MeanW-1:0];
        end
        if (cmd.zero)
        begin
            um_reg <= est_m_reg;
            uv_reg <= '0;
        end
        if (cmd.save_var)
        begin
            uv_reg <= q_reg;
        end
        if (cmd.finish)
        begin
            out_um_reg <= um_reg;
            out_uv_reg <= uv_reg;
            out_pm_reg <= pm_c;
            out_pv_reg <= pv_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.s_zero   = (s_reg == '0);
    assign status.out_free = !out_valid_reg || result.ready;

    assign result.valid              = out_valid_reg;
    assign result.updated_mean       = out_um_reg;
    assign result.updated_variance   = out_uv_reg;
    assign result.predicted_mean     = out_pm_reg;
    assign result.predicted_variance = out_pv_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cmd.step |-> r_reg < s_reg)
        else $error("divider remainder reached the divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.save_var |=> (uv_reg <= rm_reg) && (uv_reg <= est_v_reg))
        else $error("updated variance exceeds an input variance");

    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.finish |=> (est_m_reg == result.predicted_mean)
                                    && (est_v_reg == result.predicted_variance))
        else $error("estimate and reported prediction differ");

endmodule

[hw/rtl/kalman_filter_1d_top.sv]
// Channel   Direction  Transfer when      Payload
// sample    in         valid && ready     measurement, motion, restart
// result    out        valid && ready     updated_mean/variance, predicted_mean/variance
// cfg       in         cfg_write_en       cfg_index, cfg_data
//
// A new sample is accepted only once the previous item is written to the output register.
// Processing runs on one radix-2 multiply-divide step unit: 33 steps for the mean, 49 for
// the variance, plus setup and save cycles; a zero denominator skips both runs.
// A finished result waits in the output register while the next sample is accepted.
// Reset restores the register defaults and the initial estimate.
module kalman_filter_1d_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [kf1d_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [kf1d_pkg::CfgDataW-1:0]   cfg_data,
    kf1d_in_if.sink                         sample,
    kf1d_out_if.source                      result
);

    kf1d_pkg::cmd_t    cmd;
    kf1d_pkg::status_t status;
    logic              in_ready;

    assign sample.ready = in_ready;

    kf1d_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kf1d_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int StallLimit = 20000;
    localparam logic [kf1d_pkg::CfgIdxW-1:0] CfgIdxSpare = 8'd4;
    localparam logic [kf1d_pkg::CfgIdxW-1:0] CfgIdxLast  = 8'hFF;
    localparam kf1d_pkg::mean_t MeanMaxV = 32'sh7FFF_FFFF;
    localparam kf1d_pkg::mean_t MeanMinV = 32'sh8000_0000;
    localparam longint MeanHi = 64'sd2147483647;
    localparam longint MeanLo = -64'sd2147483648;

    typedef struct packed {
        kf1d_pkg::mean_t measurement;
        kf1d_pkg::mean_t motion;
        logic            restart;
        logic            hold;
    } sample_item_t;

    typedef struct packed {
        kf1d_pkg::mean_t updated_mean;
        kf1d_pkg::var_t  updated_variance;
        kf1d_pkg::mean_t predicted_mean;
        kf1d_pkg::var_t  predicted_variance;
    } estimate_pair_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [kf1d_pkg::CfgIdxW-1:0] cfg_index;
    logic [kf1d_pkg::CfgDataW-1:0] cfg_data;

    kf1d_in_if  sample_if ();
    kf1d_out_if result_if ();

    kalman_filter_1d_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_if),
        .result       (result_if)
    );

    kf1d_pkg::mean_t est_mean;
    kf1d_pkg::var_t  est_var;
    kf1d_pkg::var_t  meas_var;
    kf1d_pkg::var_t  motion_var;
    kf1d_pkg::mean_t init_mean;
    kf1d_pkg::var_t  init_var;

    sample_item_t   sample_q[$];
    estimate_pair_t estimate_q[$];
    sample_item_t   next_sample;

    logic sample_taken;
    logic in_idle_en;
    logic out_idle_en;
    int   in_gap;
    int   out_gap;
    int   idle_cycles;
    int   errors;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic estimate_pair_t filter_step(input kf1d_pkg::mean_t z,
                                                   input kf1d_pkg::mean_t mot,
                                                   input logic restart);
        estimate_pair_t res;
        longint m;
        longint d;
        longint um;
        longint pm;
        logic [63:0] mag;
        logic [127:0] denom;
        logic [127:0] quot;
        logic [kf1d_pkg::VarW:0] pv;
        if (restart)
        begin
            est_mean = init_mean;
            est_var  = init_var;
        end
        m = longint'(est_mean);
        denom = 128'(est_var) + 128'(meas_var);
        if (denom == 0)
        begin
            um = m;
            res.updated_variance = '0;
        end
        else
        begin
            d = longint'(z) - m;
            mag = (d < 0) ? -d : d;
            quot = (128'(mag) * 128'(est_var)) / denom;
            um = (d < 0) ? m - $signed(quot[63:0]) : m + $signed(quot[63:0]);
            quot = (128'(est_var) * 128'(meas_var)) / denom;
            res.updated_variance = quot[kf1d_pkg::VarW-1:0];
        end
        pm = um + longint'(mot);
        if (pm > MeanHi)
            pm = MeanHi;
        else if (pm < MeanLo)
            pm = MeanLo;
        pv = (kf1d_pkg::VarW+1)'(res.updated_variance) + (kf1d_pkg::VarW+1)'(motion_var);
        res.predicted_variance = pv[kf1d_pkg::VarW] ? '1 : pv[kf1d_pkg::VarW-1:0];
        res.updated_mean = um[kf1d_pkg::MeanW-1:0];
        res.predicted_mean = pm[kf1d_pkg::MeanW-1:0];
        est_mean = res.predicted_mean;
        est_var  = res.predicted_variance;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 24);
        return $urandom_range(60, 250);
    endfunction

    function automatic kf1d_pkg::mean_t rand_position();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                return kf1d_pkg::mean_t'(int'($urandom_range(0, 2097152)) - 1048576);
            5, 6, 7:       return kf1d_pkg::mean_t'($urandom);
            8:             return $urandom_range(0, 1) ? MeanMaxV : MeanMinV;
            default:       return kf1d_pkg::mean_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic kf1d_pkg::mean_t rand_motion();
        case ($urandom_range(0, 19))
            0, 1:    return kf1d_pkg::mean_t'($urandom);
            2:       return $urandom_range(0, 1) ? MeanMaxV : MeanMinV;
            default: return kf1d_pkg::mean_t'(int'($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic kf1d_pkg::var_t rand_variance();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return kf1d_pkg::var_t'($urandom_range(1, 65536));
            2, 3, 4: return kf1d_pkg::var_t'($urandom_range(65536, 32'h0100_0000));
            5:       return kf1d_pkg::var_t'($urandom) << $urandom_range(0, 16);
            default: return kf1d_pkg::var_t'({$urandom, $urandom});
        endcase
    endfunction

    task automatic queue_sample(input kf1d_pkg::mean_t z, input kf1d_pkg::mean_t mot,
                                input logic restart, input logic hold);
        sample_item_t item;
        item.measurement = z;
        item.motion      = mot;
        item.restart     = restart;
        item.hold        = hold;
        sample_q.push_back(item);
    endtask

    task automatic cfg_write(input logic [kf1d_pkg::CfgIdxW-1:0] idx,
                             input logic [kf1d_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            kf1d_pkg::CFG_MEAS_VAR:   meas_var   = data[kf1d_pkg::VarW-1:0];
            kf1d_pkg::CFG_MOTION_VAR: motion_var = data[kf1d_pkg::VarW-1:0];
            kf1d_pkg::CFG_INIT_MEAN:  init_mean  = data[kf1d_pkg::MeanW-1:0];
            kf1d_pkg::CFG_INIT_VAR:   init_var   = data[kf1d_pkg::VarW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || sample_if.valid || estimate_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        estimate_pair_t want;
        if (rst_n)
        begin
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                || cfg_write_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (sample_if.valid && sample_if.ready)
            begin
                estimate_q.push_back(filter_step(sample_if.measurement, sample_if.motion,
                                                 sample_if.restart));
                sample_taken = 1'b1;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    check_field("updated_mean", 64'(want.updated_mean),
                                64'(result_if.updated_mean));
                    check_field("updated_variance", 64'(want.updated_variance),
                                64'(result_if.updated_variance));
                    check_field("predicted_mean", 64'(want.predicted_mean),
                                64'(result_if.predicted_mean));
                    check_field("predicted_variance", 64'(want.predicted_variance),
                                64'(result_if.predicted_variance));
                end
            end
            if (idle_cycles >= StallLimit)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_taken || !sample_if.valid)
            begin
                if (in_gap != 0)
                begin
                    sample_if.valid <= 1'b0;
                    in_gap--;
                end
                else if (sample_q.size() != 0
                         && !(sample_q[0].hold && estimate_q.size() != 0))
                begin
                    next_sample = sample_q.pop_front();
                    sample_if.valid       <= 1'b1;
                    sample_if.measurement <= next_sample.measurement;
                    sample_if.motion      <= next_sample.motion;
                    sample_if.restart     <= next_sample.restart;
                    in_gap = in_idle_en ? pick_gap() : 0;
                end
                else
                begin
                    sample_if.valid <= 1'b0;
                end
            end
            sample_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap != 0)
            begin
                result_if.ready <= 1'b0;
                out_gap--;
            end
            else if (out_idle_en && $urandom_range(0, 11) == 0)
            begin
                result_if.ready <= 1'b0;
                out_gap = pick_gap();
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int phase;
        int k;
        kf1d_pkg::var_t rm;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.measurement = '0;
        sample_if.motion = '0;
        sample_if.restart = 1'b0;
        result_if.ready = 1'b0;
        sample_taken = 1'b0;
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        in_gap = 0;
        out_gap = 0;
        idle_cycles = 0;
        errors = 0;
        meas_var = kf1d_pkg::MeasVarRst;
        motion_var = kf1d_pkg::MotionVarRst;
        init_mean = kf1d_pkg::InitMeanRst;
        init_var = kf1d_pkg::InitVarRst;
        est_mean = kf1d_pkg::InitMeanRst;
        est_var = kf1d_pkg::InitVarRst;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: saturation of the mean at both ends and alternating bit patterns.
        queue_sample(32'sh0, 32'sh0, 1'b1, 1'b0);
        queue_sample(MeanMaxV, MeanMaxV, 1'b0, 1'b0);
        queue_sample(MeanMinV, MeanMinV, 1'b0, 1'b0);
        queue_sample(32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, 1'b0);
        queue_sample(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 1'b0);
        queue_sample(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 1'b0);
        queue_sample(32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0);
        wait_drained();

        // Zero measurement noise and zero estimate variance leave the denominator at zero.
        cfg_write(kf1d_pkg::CFG_MEAS_VAR, '0);
        cfg_write(kf1d_pkg::CFG_MOTION_VAR, '0);
        cfg_write(kf1d_pkg::CFG_INIT_MEAN, 48'hABCD_8000_0000);
        cfg_write(kf1d_pkg::CFG_INIT_VAR, '0);
        cfg_write(CfgIdxSpare, '1);
        cfg_write(CfgIdxLast, '1);
        queue_sample(MeanMaxV, 32'sh0, 1'b1, 1'b0);
        queue_sample(32'sh0, 32'shFFFF_FFFF, 1'b0, 1'b0);
        wait_drained();

        // Zero measurement noise with a large estimate variance snaps the mean to the measurement.
        cfg_write(kf1d_pkg::CFG_INIT_VAR, '1);
        cfg_write(kf1d_pkg::CFG_MOTION_VAR, '1);
        cfg_write(kf1d_pkg::CFG_INIT_MEAN, 48'hFFFF_7FFF_FFFF);
        queue_sample(MeanMinV, 32'sh0, 1'b1, 1'b0);
        queue_sample(32'sh0000_1234, MeanMaxV, 1'b0, 1'b0);
        wait_drained();

        // Largest variances saturate the predicted variance.
        cfg_write(kf1d_pkg::CFG_MEAS_VAR, '1);
        cfg_write(kf1d_pkg::CFG_INIT_MEAN, 48'h0000_8000_0000);
        queue_sample(MeanMaxV, MeanMaxV, 1'b1, 1'b0);
        queue_sample(32'sh0, 32'sh0, 1'b0, 1'b0);
        queue_sample(MeanMinV, MeanMinV, 1'b0, 1'b0);
        wait_drained();

        cfg_write(kf1d_pkg::CFG_MEAS_VAR, 48'd1);
        cfg_write(kf1d_pkg::CFG_MOTION_VAR, '0);
        queue_sample(32'sh1234_5678, 32'sh0, 1'b1, 1'b0);
        queue_sample(32'shEDCB_A988, 32'sh0001_0000, 1'b0, 1'b0);
        wait_drained();

        for (phase = 0; phase < 6; phase++)
        begin
            in_idle_en  = (phase % 3 != 1) && (phase != 5);
            out_idle_en = (phase % 3 != 2) && (phase != 5);
            rm = rand_variance();
            if (rm == 0)
                rm = 48'd1;
            cfg_write(kf1d_pkg::CFG_MEAS_VAR, rm);
            cfg_write(kf1d_pkg::CFG_MOTION_VAR,
                      ($urandom_range(0, 7) == 0) ? '0 : rand_variance());
            cfg_write(kf1d_pkg::CFG_INIT_MEAN, kf1d_pkg::CfgDataW'({$urandom, $urandom}));
            cfg_write(kf1d_pkg::CFG_INIT_VAR, rand_variance());
            for (k = 0; k < 100; k++)
                queue_sample(rand_position(), rand_motion(),
                             k == 0 || $urandom_range(0, 19) == 0,
                             (phase == 0 && k == 40) || $urandom_range(0, 99) == 0);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/kf1d_pkg.sv
hw/rtl/kf1d_if.sv
hw/rtl/kf1d_ctrl.sv
hw/rtl/kf1d_dp.sv
hw/rtl/kalman_filter_1d_top.sv
test/tb_top.sv
